>>> src/rspe_pkg.sv
// Shared constants, types and GF(2^8) helpers for the Reed-Solomon parity encoder.
// No dependencies; every file but the checker refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rspe_pkg;

    // Generator storage: one slot per coefficient of the largest generator.
    localparam int GEN_SLOTS = 32;
    localparam int REM_SLOTS = GEN_SLOTS - 1;
    localparam int CNT_W = $clog2(GEN_SLOTS);
    localparam int CFG_W = 5;
    localparam int PARITY_RESET = 10;

    // Field polynomial x^8+x^4+x^3+x^2+1 without its top term.
    localparam logic [7:0] FIELD_LOW = 8'h1D;
    localparam logic [7:0] FIELD_TOP = 8'h80;

    // Depth of the queue between the intake and the encoder core.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Remainder and reversed generator taps, entry 0 in the low byte.
    typedef logic [REM_SLOTS-1:0][7:0] rem_vec_t;

    // One queued message byte with its end-of-message tag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } q_entry_t;

    // Control from the tap builder to the intake and the core.
    typedef struct packed {
        logic busy;
        logic clear;
    } tap_ctrl_t;

    // Multiply by alpha, reducing by the field polynomial.
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] shl;
        shl = {a[6:0], 1'b0};
        return ((a & FIELD_TOP) != 8'h00) ? (shl ^ FIELD_LOW) : shl;
    endfunction

    // Full GF(2^8) product, shift-and-add over the eight bits of b.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x = a;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

    // Limit a written parity count to the range the generator storage holds.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0)
        begin
            res = CNT_W'(1);
        end
        else if (int'(v) > REM_SLOTS)
        begin
            res = CNT_W'(REM_SLOTS);
        end
        else
        begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/rspe_front.sv
// Intake side of the encoder: accepts message bytes and queues them with their last tag.
// Depends on rspe_pkg for the queue depth and entry type.
`timescale 1ns / 1ps
`default_nettype none

module rspe_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [7:0]          s_axis_tdata,
    input  wire                 s_axis_tlast,
    input  rspe_pkg::tap_ctrl_t ctrl,
    input  wire                 pop,
    output logic                q_valid,
    output rspe_pkg::q_entry_t  q_head
);

    rspe_pkg::q_entry_t            mem_reg [rspe_pkg::Q_DEPTH];
    logic [rspe_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [rspe_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [rspe_pkg::Q_PTR_W:0]    count_reg;
    logic [rspe_pkg::Q_PTR_W:0]    count_next;
    logic                          push;
    logic                          do_pop;

    // Requests are held off while the generator is being built or the queue is full.
    assign s_axis_tready = !ctrl.busy &&
                           (count_reg != (rspe_pkg::Q_PTR_W + 1)'(rspe_pkg::Q_DEPTH));
    assign push = s_axis_tvalid && s_axis_tready;
    assign q_valid = (count_reg != '0);
    assign do_pop = pop && q_valid;
    assign q_head = mem_reg[rd_ptr_reg];

    assign count_next = count_reg + (rspe_pkg::Q_PTR_W + 1)'(push)
                                  - (rspe_pkg::Q_PTR_W + 1)'(do_pop);

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rspe_pkg::Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rspe_pkg::Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Queue storage; each entry carries the byte and whether it ends the message.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data: s_axis_tdata, last: s_axis_tlast};
        end
    end

endmodule

`default_nettype wire

>>> src/rspe_tap_gen.sv
// Parity count register and iterative generator polynomial builder.
// Depends on rspe_pkg for the GF helpers, the clamp and the tap vector type.
`timescale 1ns / 1ps
`default_nettype none

module rspe_tap_gen (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [rspe_pkg::CFG_W-1:0]    cfg_data,
    output rspe_pkg::rem_vec_t            taps,
    output logic [rspe_pkg::CNT_W-1:0]    parity_count,
    output rspe_pkg::tap_ctrl_t           ctrl
);

    // Taps are kept leading term first without the implicit leading 1:
    // taps_reg[j] is the coefficient of x^(n-1-j), which is the order the LFSR uses.
    rspe_pkg::rem_vec_t             taps_reg;
    rspe_pkg::rem_vec_t             taps_next;
    logic [7:0]                     root_reg;
    logic [rspe_pkg::CNT_W-1:0]     n_reg;
    logic [rspe_pkg::CNT_W-1:0]     steps_reg;
    logic [rspe_pkg::CNT_W-1:0]     cfg_count;
    logic                           cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_count = rspe_pkg::clamp_count(cfg_data);

    assign taps = taps_reg;
    assign parity_count = n_reg;
    assign ctrl.busy = (steps_reg != '0) || cfg_write;
    assign ctrl.clear = cfg_write;

    // One factor (x + root) per cycle: each coefficient adds root times its higher neighbor.
    always_comb
    begin
        for (int j = 0; j < rspe_pkg::REM_SLOTS; j++)
        begin
            if (j == 0)
            begin
                taps_next[j] = taps_reg[j] ^ root_reg;
            end
            else
            begin
                taps_next[j] = taps_reg[j] ^ rspe_pkg::gf_mul(taps_reg[j-1], root_reg);
            end
        end
    end

    // Build sequencer; reset starts a build for the default parity count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= rspe_pkg::clamp_count(rspe_pkg::CFG_W'(rspe_pkg::PARITY_RESET));
            steps_reg <= rspe_pkg::clamp_count(rspe_pkg::CFG_W'(rspe_pkg::PARITY_RESET));
            root_reg  <= 8'h01;
            taps_reg  <= '0;
        end
        else if (cfg_write)
        begin
            n_reg     <= cfg_count;
            steps_reg <= cfg_count;
            root_reg  <= 8'h01;
            taps_reg  <= '0;
        end
        else if (steps_reg != '0)
        begin
            taps_reg  <= taps_next;
            root_reg  <= rspe_pkg::gf_xtime(root_reg);
            steps_reg <= steps_reg - rspe_pkg::CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> src/rspe_back.sv
// Encoder core: LFSR division per message byte, parity burst and the output register.
// Depends on rspe_pkg for the GF multiply, the queue entry and the tap vector types.
`timescale 1ns / 1ps
`default_nettype none

module rspe_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  rspe_pkg::tap_ctrl_t         ctrl,
    input  rspe_pkg::rem_vec_t          taps,
    input  wire  [rspe_pkg::CNT_W-1:0]  parity_count,
    input  wire                         q_valid,
    input  rspe_pkg::q_entry_t          q_head,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser
);

    typedef enum logic [1:0] {
        ST_DATA   = 2'b01,
        ST_PARITY = 2'b10
    } back_state_t;

    back_state_t                  state_reg;
    back_state_t                  state_next;
    rspe_pkg::rem_vec_t           rem_reg;
    rspe_pkg::rem_vec_t           rem_next;
    rspe_pkg::rem_vec_t           rem_lfsr;
    rspe_pkg::rem_vec_t           rem_shift;
    logic [rspe_pkg::CNT_W-1:0]   left_reg;
    logic [rspe_pkg::CNT_W-1:0]   left_next;
    logic                         ov_reg;
    logic                         ov_next;
    logic [7:0]                   obyte_reg;
    logic [7:0]                   obyte_next;
    logic                         opar_reg;
    logic                         opar_next;
    logic                         oeoc_reg;
    logic                         oeoc_next;
    logic [7:0]                   fb;
    logic                         adv;
    logic                         par_load;

    // The output register can take a new result when empty or being drained.
    assign adv = !ov_reg || m_axis_tready;
    assign q_pop = (state_reg == ST_DATA) && q_valid && adv && !ctrl.busy;
    assign par_load = (state_reg == ST_PARITY) && adv;

    // LFSR step; taps beyond the parity count are zero, so unused remainder bytes stay zero.
    assign fb = q_head.data ^ rem_reg[0];
    always_comb
    begin
        for (int j = 0; j < rspe_pkg::REM_SLOTS; j++)
        begin
            if (j == rspe_pkg::REM_SLOTS - 1)
            begin
                rem_lfsr[j] = rspe_pkg::gf_mul(fb, taps[j]);
            end
            else
            begin
                rem_lfsr[j] = rem_reg[j+1] ^ rspe_pkg::gf_mul(fb, taps[j]);
            end
        end
    end

    // Parity readout shifts the remainder down, which leaves it cleared after n bytes.
    assign rem_shift = {8'h00, rem_reg[rspe_pkg::REM_SLOTS-1:1]};

    // Next-state and result selection.
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        left_next  = left_reg;
        obyte_next = obyte_reg;
        opar_next  = opar_reg;
        oeoc_next  = oeoc_reg;
        unique case (state_reg)
            ST_DATA:
            begin
                if (q_pop)
                begin
                    rem_next   = rem_lfsr;
                    obyte_next = q_head.data;
                    opar_next  = 1'b0;
                    oeoc_next  = 1'b0;
                    if (q_head.last)
                    begin
                        state_next = ST_PARITY;
                        left_next  = parity_count;
                    end
                end
            end
            ST_PARITY:
            begin
                if (adv)
                begin
                    rem_next   = rem_shift;
                    obyte_next = rem_reg[0];
                    opar_next  = 1'b1;
                    oeoc_next  = (left_reg == rspe_pkg::CNT_W'(1));
                    left_next  = left_reg - rspe_pkg::CNT_W'(1);
                    if (left_reg == rspe_pkg::CNT_W'(1))
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
        ov_next = q_pop || par_load || (ov_reg && !m_axis_tready);
    end

    // Control state and the remainder; a configuration write empties the codeword.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DATA;
            rem_reg   <= '0;
            left_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            state_reg <= ST_DATA;
            rem_reg   <= '0;
            left_reg  <= '0;
            ov_reg    <= ov_reg && !m_axis_tready;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            left_reg  <= left_next;
            ov_reg    <= ov_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        opar_reg  <= opar_next;
        oeoc_reg  <= oeoc_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tuser  = opar_reg;
    assign m_axis_tlast  = oeoc_reg;

endmodule

`default_nettype wire

>>> src/rs_parity_encoder_gf256_top.sv
// Top level of the systematic Reed-Solomon GF(2^8) parity encoder.
// Depends on rspe_pkg, rspe_front, rspe_tap_gen and rspe_back.
//
//  Channel   Dir  Signals                        Contents
//  s_axis    in   tvalid/tready/tdata/tlast      message byte, last byte of message
//  m_axis    out  tvalid/tready/tdata/tuser/tlast echoed or parity byte, parity flag, end
//  cfg       in   cfg_valid/cfg_ready/cfg_data   parity count n (0 is taken as 1)
//
// A message byte is taken every cycle while the queue has room and no build runs, and
// its echo leaves in the cycle after it reaches the encoder core, which updates all
// remainder bytes in that same cycle. After a last byte the n parity bytes follow at one
// per cycle while the sink takes them. After reset and after each parity count write the
// generator is built one root per cycle for n roots (10 after reset), with s_axis_tready
// held low. A four-entry queue lets the intake keep taking bytes while the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module rs_parity_encoder_gf256_top (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire  [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  wire                         s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,   // [0] is_parity
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [rspe_pkg::CFG_W-1:0]  cfg_data
);

    rspe_pkg::tap_ctrl_t          ctrl;
    rspe_pkg::rem_vec_t           taps;
    logic [rspe_pkg::CNT_W-1:0]   parity_count;
    logic                         q_valid;
    rspe_pkg::q_entry_t           q_head;
    logic                         q_pop;

    // Generator builder and parity count register.
    rspe_tap_gen u_tap_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .taps         (taps),
        .parity_count (parity_count),
        .ctrl         (ctrl)
    );

    // Intake and queue.
    rspe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .ctrl          (ctrl),
        .pop           (q_pop),
        .q_valid       (q_valid),
        .q_head        (q_head)
    );

    // Encoder core and output register.
    rspe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .taps          (taps),
        .parity_count  (parity_count),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> src/rspe_checker.sv
// Port-level checks for the Reed-Solomon parity encoder, bound to its top level.
// Depends on rs_parity_encoder_gf256_top, whose handshake ports it watches.
`timescale 1ns / 1ps
`default_nettype none

module rspe_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         s_axis_tvalid,
    input wire                         s_axis_tready,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [7:0]                   m_axis_tdata,
    input wire                         m_axis_tlast,
    input wire                         m_axis_tuser,
    input wire                         cfg_valid,
    input wire                         cfg_ready
);

    logic cfg_write;
    logic out_take;
    logic in_take;

    assign cfg_write = cfg_valid && cfg_ready;
    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign in_take   = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Only a parity byte may close a codeword.
    a_end_is_parity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("end of codeword on a non-parity byte");

    // A parity count write starts a generator build, which blocks new requests.
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !s_axis_tready)
        else $error("input accepted right after a parity count write");

    // A parity burst runs without gaps while the sink keeps taking bytes.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && m_axis_tuser && !m_axis_tlast && !cfg_write |=>
            m_axis_tvalid && m_axis_tuser)
        else $error("parity burst broken before its final byte");

    // Input requests are not taken in the cycle a parity count write lands.
    a_no_input_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> !in_take)
        else $error("input accepted together with a parity count write");

endmodule

bind rs_parity_encoder_gf256_top rspe_checker u_rspe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

>>> tb/tb_rs_parity_encoder_gf256_top.sv
// Testbench for the Reed-Solomon GF(2^8) parity encoder top level.
// It predicts echoes and parity bytes with its own LFSR division and checks every output request.
// Depends on rspe_pkg and rs_parity_encoder_gf256_top.
`timescale 1ns / 1ps

module tb_rs_parity_encoder_gf256_top;

    localparam int SINK_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 40;

    // One expected output byte of a codeword.
    typedef struct {
        logic [7:0] value;
        logic       parity;
        logic       eoc;
    } cw_byte_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata;
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [7:0]                  m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        m_axis_tuser;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [rspe_pkg::CFG_W-1:0]  cfg_data;

    // Predictor state: remainder, generator taps and parity count.
    logic [7:0] rem_bytes [rspe_pkg::REM_SLOTS];
    logic [7:0] gen_taps [rspe_pkg::GEN_SLOTS];
    int         n_parity;

    cw_byte_t   codeword_q [$];
    int         err_count;
    bit         idle_on;
    bit         sink_hold_req;

    rs_parity_encoder_gf256_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #12000000;
        $display("Some tests failed");
        $finish;
    end

    // Product in GF(2^8) with the 0x11D field polynomial.
    function automatic logic [7:0] gf8_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x = a;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1D) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Clamp the count, rebuild g(x) = prod (x - alpha^i) and clear the remainder.
    task automatic set_generator(input logic [rspe_pkg::CFG_W-1:0] v);
        logic [7:0] root;
        if (v == '0)
        begin
            n_parity = 1;
        end
        else if (int'(v) > rspe_pkg::REM_SLOTS)
        begin
            n_parity = rspe_pkg::REM_SLOTS;
        end
        else
        begin
            n_parity = int'(v);
        end
        foreach (gen_taps[k])
        begin
            gen_taps[k] = 8'h00;
        end
        gen_taps[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < n_parity; i++)
        begin
            for (int k = i + 1; k >= 1; k--)
            begin
                gen_taps[k] = gen_taps[k - 1] ^ gf8_mul(gen_taps[k], root);
            end
            gen_taps[0] = gf8_mul(gen_taps[0], root);
            root = gf8_mul(root, 8'h02);
        end
        foreach (rem_bytes[j])
        begin
            rem_bytes[j] = 8'h00;
        end
    endtask

    // One LFSR division step; queues the echo and, on a last byte, the parity burst.
    task automatic rs_encode_byte(input logic [7:0] d, input logic last);
        logic [7:0] fb;
        cw_byte_t   cb;
        fb = d ^ rem_bytes[0];
        for (int j = 0; j + 1 < n_parity; j++)
        begin
            rem_bytes[j] = rem_bytes[j + 1] ^ gf8_mul(fb, gen_taps[n_parity - 1 - j]);
        end
        rem_bytes[n_parity - 1] = gf8_mul(fb, gen_taps[0]);
        cb.value = d;
        cb.parity = 1'b0;
        cb.eoc = 1'b0;
        codeword_q.push_back(cb);
        if (last)
        begin
            for (int j = 0; j < n_parity; j++)
            begin
                cb.value = rem_bytes[j];
                cb.parity = 1'b1;
                cb.eoc = (j == n_parity - 1);
                codeword_q.push_back(cb);
                rem_bytes[j] = 8'h00;
            end
        end
    endtask

    // Mostly short gaps, a few long ones; none when idling is off.
    function automatic int pick_gap(input bit en);
        int r;
        if (!en)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 96)
        begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 20);
    endfunction

    // Offer one message byte and wait until the request is taken.
    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = pick_gap(idle_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        rs_encode_byte(d, last);
    endtask

    // Stop offering and wait until every expected byte has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (codeword_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the parity count register; only called with the block idle.
    task automatic write_parity_count(input logic [rspe_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_generator(v);
    endtask

    // Output side: ready with random gaps, and a long hold when one is requested.
    initial
    begin : sink_ready
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                m_axis_tready <= 1'b0;
                gap_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                gap_left = pick_gap(idle_on);
            end
        end
    end

    // Compare each output request with the oldest expected byte.
    always @(posedge clk)
    begin : out_check
        cw_byte_t exp_b;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (codeword_q.size() == 0)
            begin
                $display("%0t: unexpected output byte=%02h parity=%0b eoc=%0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end
            else
            begin
                exp_b = codeword_q.pop_front();
                if (m_axis_tdata !== exp_b.value)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, exp_b.value, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser !== exp_b.parity)
                begin
                    $display("%0t: is_parity expected %0b actual %0b",
                             $time, exp_b.parity, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tlast !== exp_b.eoc)
                begin
                    $display("%0t: end_of_codeword expected %0b actual %0b",
                             $time, exp_b.eoc, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Reset count of ten: extreme byte values and a one-byte codeword.
    task automatic test_reset_count();
        idle_on = 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        idle_on = 1'b1;
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        wait_drained();
    endtask

    // Smallest and largest counts; a written zero is taken as one.
    task automatic test_count_extremes();
        write_parity_count('0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b1);
        wait_drained();
        write_parity_count(5'd31);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hC3, 1'b1);
        wait_drained();
        write_parity_count(5'd1);
        send_byte(8'h9A, 1'b1);
        wait_drained();
    endtask

    // A count write in the middle of a codeword starts it over empty.
    task automatic test_midword_write();
        write_parity_count(5'd7);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hE1, 1'b0);
        wait_drained();
        write_parity_count(5'd4);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h0F, 1'b1);
        wait_drained();
    endtask

    // The output holds off for a long stretch while bytes keep coming.
    task automatic test_output_stall();
        write_parity_count(5'd6);
        idle_on = 1'b0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            send_byte(8'($urandom), (i % 6) == 5);
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    // Random codewords over random counts; segments may end mid-codeword.
    task automatic test_random_codewords();
        int sent;
        int seg_left;
        int msg_len;
        int pick;
        logic [rspe_pkg::CFG_W-1:0] cnt_val;
        sent = 0;
        while (sent < 320)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                cnt_val = '0;
            end
            else if (pick == 1)
            begin
                cnt_val = 5'd31;
            end
            else if (pick == 2)
            begin
                cnt_val = 5'd1;
            end
            else
            begin
                cnt_val = 5'($urandom_range(0, 31));
            end
            write_parity_count(cnt_val);
            idle_on = ($urandom_range(0, 3) != 0);
            seg_left = $urandom_range(20, 50);
            while (seg_left > 0)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    msg_len = $urandom_range(12, 30);
                end
                else
                begin
                    msg_len = $urandom_range(1, 8);
                end
                for (int i = 0; i < msg_len && seg_left > 0; i++)
                begin
                    send_byte(8'($urandom), i == msg_len - 1);
                    sent++;
                    seg_left--;
                end
            end
            wait_drained();
        end
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial
    begin
        err_count = 0;
        idle_on = 1'b0;
        sink_hold_req = 1'b0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        s_axis_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        set_generator(rspe_pkg::CFG_W'(rspe_pkg::PARITY_RESET));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_count_extremes();
        test_midword_write();
        test_output_stall();
        test_random_codewords();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && codeword_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> rs_parity_encoder_gf256_top.f
src/rspe_pkg.sv
src/rspe_front.sv
src/rspe_tap_gen.sv
src/rspe_back.sv
src/rs_parity_encoder_gf256_top.sv
src/rspe_checker.sv
tb/tb_rs_parity_encoder_gf256_top.sv
